// ----- rtl/lkv_pkg.sv -----
package lkv_pkg;

  // table geometry
  localparam int CAPACITY   = 256;
  localparam int KEY_BITS   = 8;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  // cells are reduced in groups so that no combining stage spans the whole row
  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef logic [KEY_BITS-1:0]          key_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0]        count_t;

  localparam count_t CAP_COUNT = count_t'(CAPACITY);

  // request codes; the unused code behaves as a lookup
  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_PUT    = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  // request word
  typedef struct packed {
    logic [1:0] action;
    key_t       key;
    value_t     value;
  } req_t;

  // result word
  typedef struct packed {
    logic   found;
    value_t value_out;
    logic   rejected;
    count_t entry_count;
  } rsp_t;

  // broadcast commands to the cell row
  typedef struct packed {
    logic cmp;
    logic update;
    logic append;
    logic shift;
  } cell_ctrl_t;

  // combined lookup outcome from the reduction tree
  typedef struct packed {
    logic   hit;
    value_t value;
  } sum_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED,
    ST_SUM,
    ST_UPD
  } state_e;

endpackage

// ----- rtl/lkv_cell.sv -----
module lkv_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lkv_pkg::cell_ctrl_t ctrl_i,
  input  lkv_pkg::key_t       req_key_i,
  input  lkv_pkg::value_t     req_value_i,
  input  logic                prev_valid_i,
  input  logic                next_valid_i,
  input  lkv_pkg::key_t       next_key_i,
  input  lkv_pkg::value_t     next_value_i,
  input  logic                seen_i,
  output logic                valid_o,
  output lkv_pkg::key_t       key_o,
  output lkv_pkg::value_t     value_o,
  output logic                match_o,
  output logic                seen_o
);
  import lkv_pkg::*;

  logic   valid_q;
  key_t   key_q;
  value_t value_q;
  logic   match_q;
  logic   tail;
  logic   take_next;

  // first free slot sits right after the last occupied one
  assign tail      = prev_valid_i && !valid_q;
  // a match at or before this slot pulls the neighbour's entry down
  assign seen_o    = seen_i || match_q;
  assign take_next = ctrl_i.shift && seen_o;

  // key compare, held until the next request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      match_q <= valid_q && (key_q == req_key_i);
    end
  end

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_next) begin
      valid_q <= next_valid_i;
    end else if (ctrl_i.append && tail) begin
      valid_q <= 1'b1;
    end
  end

  // entry contents
  always_ff @(posedge clk_i) begin
    if (take_next) begin
      key_q   <= next_key_i;
      value_q <= next_value_i;
    end else if (ctrl_i.append && tail) begin
      key_q   <= req_key_i;
      value_q <= req_value_i;
    end else if (ctrl_i.update && match_q) begin
      value_q <= req_value_i;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = match_q;

endmodule

// ----- rtl/lkv_reduce.sv -----
module lkv_reduce (
  input  logic            clk_i,
  input  logic            match_i  [lkv_pkg::CAPACITY],
  input  lkv_pkg::value_t value_i  [lkv_pkg::CAPACITY],
  output lkv_pkg::sum_t   sum_o,
  output logic            before_o [lkv_pkg::NUM_GROUPS]
);
  import lkv_pkg::*;

  logic   grp_any_d [NUM_GROUPS];
  value_t grp_val_d [NUM_GROUPS];
  logic   grp_any_q [NUM_GROUPS];
  value_t grp_val_q [NUM_GROUPS];
  sum_t   sum_d;
  sum_t   sum_q;
  logic   before_d  [NUM_GROUPS];
  logic   before_q  [NUM_GROUPS];

  // first level: one-hot select inside each group
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_any_d[g] = 1'b0;
      grp_val_d[g] = '0;
      for (int l = 0; l < GROUP_SIZE; l++) begin
        if (g * GROUP_SIZE + l < CAPACITY) begin
          grp_any_d[g] = grp_any_d[g] | match_i[g*GROUP_SIZE+l];
          grp_val_d[g] = grp_val_d[g] |
                         (match_i[g*GROUP_SIZE+l] ? value_i[g*GROUP_SIZE+l] : '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_any_q <= grp_any_d;
    grp_val_q <= grp_val_d;
  end

  // second level: overall hit, value and per-group "match in an earlier group"
  always_comb begin
    sum_d.hit   = 1'b0;
    sum_d.value = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      before_d[g] = sum_d.hit;
      sum_d.hit   = sum_d.hit | grp_any_q[g];
      sum_d.value = sum_d.value | (grp_any_q[g] ? grp_val_q[g] : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    before_q <= before_d;
  end

  assign sum_o    = sum_q;
  assign before_o = before_q;

endmodule

// ----- rtl/linear_key_value_table.sv -----
// a word taken at a clock edge is compared in the cells, reduced in two registered group
// levels and applied across the cell row at the update step, which registers rsp_o and
// done_o; done_o marks the result for one cycle; busy stays high until the sequencer is
// back in idle, where the next word is taken
// the receiver cannot stall; a new request may start while done_o is high
// reset clears the table (all cells empty, count zero) and miss value to zero
module linear_key_value_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  lkv_pkg::req_t   req_i,
  output logic            done_o,
  output lkv_pkg::rsp_t   rsp_o,
  input  logic            cfg_we_i,
  input  lkv_pkg::value_t cfg_wdata_i
);
  import lkv_pkg::*;

  state_e     state_q;
  state_e     state_d;
  req_t       req_q;
  count_t     count_q;
  count_t     count_d;
  value_t     miss_q;
  rsp_t       rsp_q;
  rsp_t       rsp_d;
  logic       done_q;
  cell_ctrl_t ctrl;
  sum_t       sum;
  logic       is_put;
  logic       is_rem;
  logic       is_look;
  logic       full;

  logic   cell_valid [CAPACITY];
  key_t   cell_key   [CAPACITY];
  value_t cell_value [CAPACITY];
  logic   cell_match [CAPACITY];
  logic   cell_seen  [CAPACITY];
  logic   grp_before [NUM_GROUPS];
  logic [CAPACITY-1:0] valid_vec;

  // miss value register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q <= '0;
    end else if (cfg_we_i) begin
      miss_q <= cfg_wdata_i;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start) state_d = ST_CMP;
      ST_CMP:  state_d = ST_RED;
      ST_RED:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request decode
  assign is_put  = (req_q.action == ACT_PUT);
  assign is_rem  = (req_q.action == ACT_REMOVE);
  assign is_look = !is_put && !is_rem;
  assign full    = (count_q == CAP_COUNT);

  // sequencer outputs
  always_comb begin
    busy        = 1'b1;
    ctrl        = '0;
    case (state_q)
      ST_IDLE: busy = 1'b0;
      ST_CMP:  ctrl.cmp = 1'b1;
      ST_UPD: begin
        ctrl.update = is_put && sum.hit;
        ctrl.append = is_put && !sum.hit && !full;
        ctrl.shift  = is_rem && sum.hit;
      end
      default: busy = 1'b1;
    endcase
  end

  // entry count
  always_comb begin
    count_d = count_q;
    if (ctrl.append) begin
      count_d = count_q + count_t'(1);
    end else if (ctrl.shift) begin
      count_d = count_q - count_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // result word
  always_comb begin
    rsp_d.found       = sum.hit;
    rsp_d.value_out   = (is_look && sum.hit) ? sum.value : miss_q;
    rsp_d.rejected    = is_put && !sum.hit && full;
    rsp_d.entry_count = count_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == ST_UPD);
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int Grp = i / GROUP_SIZE;
    localparam int Lane = i % GROUP_SIZE;
    logic   prev_valid;
    logic   next_valid;
    key_t   next_key;
    value_t next_value;
    logic   seen_in;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_key   = '0;
      assign next_value = '0;
    end else begin : g_mid
      assign next_valid = cell_valid[i+1];
      assign next_key   = cell_key[i+1];
      assign next_value = cell_value[i+1];
    end

    if (Lane == 0) begin : g_grp_start
      assign seen_in = grp_before[Grp];
    end else begin : g_grp_cont
      assign seen_in = cell_seen[i-1];
    end

    lkv_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .req_key_i    (req_q.key),
      .req_value_i  (req_q.value),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_key_i   (next_key),
      .next_value_i (next_value),
      .seen_i       (seen_in),
      .valid_o      (cell_valid[i]),
      .key_o        (cell_key[i]),
      .value_o      (cell_value[i]),
      .match_o      (cell_match[i]),
      .seen_o       (cell_seen[i])
    );

    assign valid_vec[i] = cell_valid[i];
  end

  // match reduction
  lkv_reduce u_reduce (
    .clk_i    (clk_i),
    .match_i  (cell_match),
    .value_i  (cell_value),
    .sum_o    (sum),
    .before_o (grp_before)
  );

  // occupancy of the row agrees with the count between requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (count_t'($countones(valid_vec)) == count_q))
    else $error("cell occupancy differs from entry count");

  // count never passes capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_COUNT)
    else $error("entry count above capacity");

  // count only moves at the update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_UPD) |=> $stable(count_q))
    else $error("entry count changed outside update");

  // a result follows the update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |=> done_o)
    else $error("missing result strobe");

  // a rejected put means a full table and an absent key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.rejected) |-> (!rsp_o.found && rsp_o.entry_count == CAP_COUNT))
    else $error("reject without full table");

endmodule
